@@ rtl/envelope_triggered_volume_swell_assert.svh @@
// Assertion macros for the envelope triggered volume swell checker
`ifndef ENVELOPE_TRIGGERED_VOLUME_SWELL_ASSERT_SVH
`define ENVELOPE_TRIGGERED_VOLUME_SWELL_ASSERT_SVH

// same-cycle implication
`define ETVS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/etvs_pkg.sv @@
// Shared constants, types and gain curve generator for the volume swell block
package etvs_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int GAIN_TABLE_DEPTH = 1024;
    localparam int GAIN_IDX_BITS    = $clog2(GAIN_TABLE_DEPTH);
    localparam int PHASE_FRAC_BITS  = 16;
    localparam int PHASE_BITS       = GAIN_IDX_BITS + PHASE_FRAC_BITS;
    localparam int RAMP_COUNT_BITS  = 20;
    localparam int COEF_BITS        = 16;
    localparam int COEF_FRAC_BITS   = 16;
    localparam int THR_BITS         = 16;
    localparam int STEP_BITS        = 24;
    localparam int ROM_BITS         = 16;
    localparam int GAIN_BITS        = ROM_BITS + 1;
    localparam int CFG_IDX_BITS     = 3;
    localparam int CFG_DATA_BITS    = (STEP_BITS > RAMP_COUNT_BITS) ? STEP_BITS : RAMP_COUNT_BITS;

    localparam logic [GAIN_BITS-1:0]   UNITY_GAIN = GAIN_BITS'(1) << ROM_BITS;
    localparam logic [SAMPLE_BITS-1:0] ENV_MAX    = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ATTACK     = 3'd0,
        CFG_DECAY      = 3'd1,
        CFG_THRESHOLD  = 3'd2,
        CFG_PHASE_STEP = 3'd3,
        CFG_LENGTH_MAX = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_BITS-1:0]       attack_coef;
        logic [COEF_BITS-1:0]       decay_coef;
        logic [THR_BITS-1:0]        swell_threshold;
        logic [STEP_BITS-1:0]       ramp_phase_step;
        logic [RAMP_COUNT_BITS-1:0] ramp_length_max;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        attack_coef:     COEF_BITS'(60000),
        decay_coef:      COEF_BITS'(65399),
        swell_threshold: THR_BITS'(655),
        ramp_phase_step: STEP_BITS'(350),
        ramp_length_max: RAMP_COUNT_BITS'(480000)
    };

    // envelope stage to ramp stage
    typedef struct packed {
        logic advance;
        logic restart;
    } t_ramp_cmd;

    typedef logic [ROM_BITS-1:0] t_gain_rom [GAIN_TABLE_DEPTH];

    // exp(-18.4/DEPTH) from a 12-term series in Q56, rounded to Q32
    localparam longint unsigned SER_ONE = 64'd1 << 56;
    localparam longint unsigned SER_DIV = 64'd5 * 64'(GAIN_TABLE_DEPTH);
    localparam longint unsigned SER_T1  = SER_ONE * 64'd92 / (SER_DIV * 64'd1);
    localparam longint unsigned SER_T2  = SER_T1 * 64'd92 / (SER_DIV * 64'd2);
    localparam longint unsigned SER_T3  = SER_T2 * 64'd92 / (SER_DIV * 64'd3);
    localparam longint unsigned SER_T4  = SER_T3 * 64'd92 / (SER_DIV * 64'd4);
    localparam longint unsigned SER_T5  = SER_T4 * 64'd92 / (SER_DIV * 64'd5);
    localparam longint unsigned SER_T6  = SER_T5 * 64'd92 / (SER_DIV * 64'd6);
    localparam longint unsigned SER_T7  = SER_T6 * 64'd92 / (SER_DIV * 64'd7);
    localparam longint unsigned SER_T8  = SER_T7 * 64'd92 / (SER_DIV * 64'd8);
    localparam longint unsigned SER_T9  = SER_T8 * 64'd92 / (SER_DIV * 64'd9);
    localparam longint unsigned SER_T10 = SER_T9 * 64'd92 / (SER_DIV * 64'd10);
    localparam longint unsigned SER_T11 = SER_T10 * 64'd92 / (SER_DIV * 64'd11);
    localparam longint unsigned SER_T12 = SER_T11 * 64'd92 / (SER_DIV * 64'd12);
    localparam longint unsigned SER_SUM = SER_ONE - SER_T1 + SER_T2 - SER_T3 + SER_T4
                                          - SER_T5 + SER_T6 - SER_T7 + SER_T8 - SER_T9
                                          + SER_T10 - SER_T11 + SER_T12;
    localparam longint unsigned GAIN_BASE_Q32 = (SER_SUM + (64'd1 << 23)) >> 24;

    // 1 - exp(-4.6u), u = 4i/DEPTH, built by repeated Q32 multiplication
    function automatic t_gain_rom build_gain_rom();
        longint unsigned e;
        longint unsigned r16;
        longint unsigned g;
        t_gain_rom       rom;
        e = 64'd1 << 32;
        for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
            r16 = (e + 64'd32768) >> 16;
            g   = 64'd65536 - r16;
            if (g > 64'd65535) begin
                g = 64'd65535;
            end
            rom[i] = g[ROM_BITS-1:0];
            e      = (e * GAIN_BASE_Q32 + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

@@ rtl/envelope_triggered_volume_swell.sv @@
// Envelope triggered volume swell: one sample per transaction, one result per sample.
// Each accepted sample updates a peak envelope; when the envelope reaches the threshold
// while no swell is armed, a 1-exp(-4.6u) gain ramp restarts from zero on that very
// sample and runs until ramp_length_max samples or the end of the 1024-entry curve ROM,
// after which gain is unity. The block takes one sample every cycle while the output is not
// stalled; each result is presented after its sample passes the input register, then the
// envelope/ramp stage with registered ROM read, then the multiply into the result
// register. The per-cycle envelope recursion through one 17x17 multiplier sets the
// rate. Input stall rises only when all three stages hold transactions and the result
// is stalled. Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while the block is idle; the block does not enforce this.
module envelope_triggered_volume_swell import etvs_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic        [SAMPLE_BITS-1:0] o_envelope_level,
    output logic                          o_swell_running,
    input  logic                          i_cfg_we,
    input  logic        [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic        [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                          r_cfg;
    logic                          r_s0_vld;
    logic signed [SAMPLE_BITS-1:0] r_s0_x;
    logic                          r_s1_vld;
    logic signed [SAMPLE_BITS-1:0] r_s1_x;
    logic        [SAMPLE_BITS-1:0] r_s1_env;
    logic                          r_out_vld;

    logic                          n_s0_vld;
    logic                          n_s1_vld;
    logic                          n_out_vld;

    logic                          w_rdy0;
    logic                          w_rdy1;
    logic                          w_rdy2;
    logic                          w_in_acc;
    logic                          w_fire0;
    logic                          w_fire1;
    logic        [SAMPLE_BITS-1:0] w_env_nxt;
    t_ramp_cmd                     w_cmd;
    logic        [ROM_BITS-1:0]    w_rom_gain;
    logic                          w_running;

    always_comb begin
        w_rdy2    = !r_out_vld || !i_out_stall;
        w_rdy1    = !r_s1_vld || w_rdy2;
        w_rdy0    = !r_s0_vld || w_rdy1;
        w_in_acc  = i_in_valid && w_rdy0;
        w_fire0   = r_s0_vld && w_rdy1;
        w_fire1   = r_s1_vld && w_rdy2;
        n_s0_vld  = w_in_acc || (r_s0_vld && !w_rdy1);
        n_s1_vld  = w_fire0 || (r_s1_vld && !w_rdy2);
        n_out_vld = w_fire1 || (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:     r_cfg.attack_coef     <= i_cfg_data[COEF_BITS-1:0];
                CFG_DECAY:      r_cfg.decay_coef      <= i_cfg_data[COEF_BITS-1:0];
                CFG_THRESHOLD:  r_cfg.swell_threshold <= i_cfg_data[THR_BITS-1:0];
                CFG_PHASE_STEP: r_cfg.ramp_phase_step <= i_cfg_data[STEP_BITS-1:0];
                CFG_LENGTH_MAX: r_cfg.ramp_length_max <= i_cfg_data[RAMP_COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s0_vld  <= n_s0_vld;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s0_x <= i_in_sample;
        end
        if (w_fire0) begin
            r_s1_x   <= r_s0_x;
            r_s1_env <= w_env_nxt;
        end
    end

    etvs_env u_env (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_fire0),
        .i_x       (r_s0_x),
        .i_cfg     (r_cfg),
        .o_env     (w_env_nxt),
        .o_cmd     (w_cmd)
    );

    etvs_ramp u_ramp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (r_cfg),
        .o_rom_gain (w_rom_gain),
        .o_running  (w_running)
    );

    etvs_gain u_gain (
        .i_clk            (i_clk),
        .i_load           (w_fire1),
        .i_x              (r_s1_x),
        .i_rom_gain       (w_rom_gain),
        .i_running        (w_running),
        .i_env            (r_s1_env),
        .o_out_sample     (o_out_sample),
        .o_envelope_level (o_envelope_level),
        .o_swell_running  (o_swell_running)
    );

    assign o_in_stall  = !w_rdy0;
    assign o_out_valid = r_out_vld;

endmodule

@@ rtl/etvs_env.sv @@
// Peak envelope follower with swell trigger and release hysteresis
module etvs_env import etvs_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  t_cfg                          i_cfg,
    output logic        [SAMPLE_BITS-1:0] o_env,
    output t_ramp_cmd                     o_cmd
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + COEF_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int WIDE_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int CMP_BITS  = WIDE_BITS + 5;

    logic        [SAMPLE_BITS-1:0] r_env;
    logic                          r_armed;
    logic        [SAMPLE_BITS-1:0] n_env;
    logic                          n_armed;

    logic        [SAMPLE_BITS-1:0] w_abs;
    logic        [COEF_BITS-1:0]   w_coef;
    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [SUM_BITS-1:0]    w_step;
    logic signed [SUM_BITS-1:0]    w_sum;
    logic        [CMP_BITS-1:0]    w_env_w;
    logic        [CMP_BITS-1:0]    w_thr_w;
    logic                          w_fired;
    logic                          w_release;

    always_comb begin
        w_abs   = i_x[SAMPLE_BITS-1] ? ($unsigned(~i_x) + 1'b1) : $unsigned(i_x);
        w_coef  = (w_abs > r_env) ? i_cfg.attack_coef : i_cfg.decay_coef;
        w_diff  = $signed({1'b0, r_env}) - $signed({1'b0, w_abs});
        w_prod  = $signed({1'b0, w_coef}) * w_diff;
        w_step  = w_prod[PROD_BITS-1:COEF_FRAC_BITS];
        w_sum   = $signed({2'b00, w_abs}) + w_step;
        n_env   = w_sum[SUM_BITS-1] ? '0 : w_sum[SAMPLE_BITS-1:0];

        w_env_w   = CMP_BITS'(n_env);
        w_thr_w   = CMP_BITS'(i_cfg.swell_threshold);
        w_fired   = !r_armed && (w_env_w >= w_thr_w);
        // release below 0.85 of threshold: 20*env < 17*thr
        w_release = ((w_env_w << 4) + (w_env_w << 2)) < ((w_thr_w << 4) + w_thr_w);

        n_armed = r_armed;
        if (w_fired) begin
            n_armed = 1'b1;
        end else if (w_release) begin
            n_armed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env   <= '0;
            r_armed <= 1'b0;
        end else if (i_advance) begin
            r_env   <= n_env;
            r_armed <= n_armed;
        end
    end

    assign o_env = n_env;
    assign o_cmd = '{advance: i_advance, restart: w_fired};

endmodule

@@ rtl/etvs_ramp.sv @@
// Gain ramp phase accumulator, sample counter and curve ROM
module etvs_ramp import etvs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ramp_cmd           i_cmd,
    input  t_cfg                i_cfg,
    output logic [ROM_BITS-1:0] o_rom_gain,
    output logic                o_running
);

    localparam int ACC_BITS = ((PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS) + 1;
    localparam t_gain_rom GAIN_ROM = build_gain_rom();

    logic                       r_active;
    logic [RAMP_COUNT_BITS-1:0] r_count;
    logic [PHASE_BITS-1:0]      r_phase;
    logic [ROM_BITS-1:0]        r_rom_q;
    logic                       r_running;

    logic                       n_active;
    logic [RAMP_COUNT_BITS-1:0] n_count;
    logic [PHASE_BITS-1:0]      n_phase;

    logic                       w_active;
    logic [RAMP_COUNT_BITS-1:0] w_count;
    logic [PHASE_BITS-1:0]      w_phase;
    logic                       w_run;
    logic [RAMP_COUNT_BITS-1:0] w_count_inc;
    logic [ACC_BITS-1:0]        w_acc;
    logic                       w_off_end;

    always_comb begin
        // a trigger restarts the ramp on the crossing sample itself
        w_active    = i_cmd.restart || r_active;
        w_count     = i_cmd.restart ? '0 : r_count;
        w_phase     = i_cmd.restart ? '0 : r_phase;
        w_run       = w_active && (w_count < i_cfg.ramp_length_max);
        w_count_inc = w_count + 1'b1;
        w_acc       = ACC_BITS'(w_phase) + ACC_BITS'(i_cfg.ramp_phase_step);
        w_off_end   = |w_acc[ACC_BITS-1:PHASE_BITS];

        if (w_run) begin
            n_active = !((w_count_inc >= i_cfg.ramp_length_max) || w_off_end);
            n_count  = w_count_inc;
            n_phase  = w_acc[PHASE_BITS-1:0];
        end else begin
            n_active = 1'b0;
            n_count  = w_count;
            n_phase  = w_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_phase  <= '0;
        end else if (i_cmd.advance) begin
            r_active <= n_active;
            r_count  <= n_count;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_rom_q   <= GAIN_ROM[w_phase[PHASE_BITS-1:PHASE_FRAC_BITS]];
            r_running <= w_run;
        end
    end

    assign o_rom_gain = r_rom_q;
    assign o_running  = r_running;

endmodule

@@ rtl/etvs_gain.sv @@
// Gain multiply and result register
module etvs_gain import etvs_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic        [ROM_BITS-1:0]    i_rom_gain,
    input  logic                          i_running,
    input  logic        [SAMPLE_BITS-1:0] i_env,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic        [SAMPLE_BITS-1:0] o_envelope_level,
    output logic                          o_swell_running
);

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic        [SAMPLE_BITS-1:0] r_envelope_level;
    logic                          r_swell_running;

    logic        [GAIN_BITS-1:0]   w_gain;
    logic signed [PROD_BITS-1:0]   w_prod;

    always_comb begin
        w_gain = i_running ? {1'b0, i_rom_gain} : UNITY_GAIN;
        w_prod = i_x * $signed({1'b0, w_gain});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out_sample     <= w_prod[ROM_BITS+SAMPLE_BITS-1:ROM_BITS];
            r_envelope_level <= i_env;
            r_swell_running  <= i_running;
        end
    end

    assign o_out_sample     = r_out_sample;
    assign o_envelope_level = r_envelope_level;
    assign o_swell_running  = r_swell_running;

endmodule

@@ rtl/etvs_checker.sv @@
// Port-level assertions for the volume swell block, bound to the top level
`include "envelope_triggered_volume_swell_assert.svh"

module etvs_checker import etvs_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [SAMPLE_BITS-1:0] o_out_sample,
    input logic        [SAMPLE_BITS-1:0] o_envelope_level,
    input logic                          o_swell_running
);

    // a stalled result transaction holds
    `ETVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_sample) && $stable(o_envelope_level) && $stable(o_swell_running), "result changed while stalled")

    // input only stalls with the pipe full behind a waiting result
    `ETVS_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid, "input stalled with no result waiting")

    // free output side always frees the input side
    `ETVS_ASSERT_SAME(a_stall_free, i_clk, i_rst_n, !i_out_stall, !o_in_stall, "input stalled while output free")

    // envelope never exceeds full scale
    `ETVS_ASSERT_SAME(a_env_range, i_clk, i_rst_n, o_out_valid, o_envelope_level <= ENV_MAX, "envelope above full scale")

endmodule

bind envelope_triggered_volume_swell etvs_checker u_etvs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_sample     (o_out_sample),
    .o_envelope_level (o_envelope_level),
    .o_swell_running  (o_swell_running)
);

@@ bench/tb_envelope_triggered_volume_swell.sv @@
// Self-checking testbench for the envelope triggered volume swell block
`timescale 1ns / 100ps

module tb_envelope_triggered_volume_swell;
    import etvs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic        [SAMPLE_BITS-1:0] level;
        logic                          running;
    } t_swell_result;

    class t_swell_scoreboard;
        logic [COEF_BITS-1:0]       attack;
        logic [COEF_BITS-1:0]       decay;
        logic [THR_BITS-1:0]        threshold;
        logic [STEP_BITS-1:0]       phase_step;
        logic [RAMP_COUNT_BITS-1:0] length_max;
        int unsigned                envelope;
        bit                         armed;
        bit                         ramp_on;
        int unsigned                ramp_count;
        longint unsigned            ramp_phase;
        logic [ROM_BITS-1:0]        gain_curve [GAIN_TABLE_DEPTH];
        t_swell_result              pending_results [$];
        int                         mismatches;
        int                         samples_noted;
        int                         checked;
        int                         ramp_results;

        function new();
            build_curve();
            attack     = CFG_RESET.attack_coef;
            decay      = CFG_RESET.decay_coef;
            threshold  = CFG_RESET.swell_threshold;
            phase_step = CFG_RESET.ramp_phase_step;
            length_max = CFG_RESET.ramp_length_max;
            envelope   = 0;
            armed      = 1'b0;
            ramp_on    = 1'b0;
            ramp_count = 0;
            ramp_phase = 0;
            mismatches = 0;
            samples_noted = 0;
            checked    = 0;
            ramp_results = 0;
        endfunction

        // 1 - exp(-4.6u) in Q16, exp base from a 12-term series, powers in Q32
        function void build_curve();
            longint unsigned series;
            longint unsigned term;
            longint unsigned ratio_q32;
            longint unsigned e_q32;
            longint unsigned rounded;
            longint unsigned g;
            series = 64'd1 << 56;
            term   = series;
            for (int k = 1; k <= 12; k++) begin
                term   = term * 64'd92 / (64'd5 * GAIN_TABLE_DEPTH * k);
                series = (k % 2 == 1) ? series - term : series + term;
            end
            ratio_q32 = (series + (64'd1 << 23)) >> 24;
            e_q32     = 64'd1 << 32;
            for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
                rounded       = (e_q32 + 64'd32768) >> 16;
                g             = 64'd65536 - rounded;
                gain_curve[i] = (g > 64'd65535) ? 16'hFFFF : g[15:0];
                e_q32         = (e_q32 * ratio_q32 + (64'd1 << 31)) >> 32;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] v);
            case (idx)
                CFG_ATTACK:     attack     = v[COEF_BITS-1:0];
                CFG_DECAY:      decay      = v[COEF_BITS-1:0];
                CFG_THRESHOLD:  threshold  = v[THR_BITS-1:0];
                CFG_PHASE_STEP: phase_step = v[STEP_BITS-1:0];
                CFG_LENGTH_MAX: length_max = v[RAMP_COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
            int            x;
            int            a;
            int            c;
            int            env_new;
            int            gain;
            longint        prod;
            longint        y;
            bit            fired;
            bit            running;
            int unsigned   idx;
            t_swell_result r;
            x = s;
            a = (x < 0) ? -x : x;
            c = (a > int'(envelope)) ? int'(attack) : int'(decay);
            prod    = longint'(c) * longint'(int'(envelope) - a);
            env_new = a + int'(prod >>> 16);
            if (env_new < 0) env_new = 0;
            envelope = env_new;

            fired = 1'b0;
            if (!armed && envelope >= threshold) begin
                armed      = 1'b1;
                fired      = 1'b1;
                ramp_on    = 1'b1;
                ramp_count = 0;
                ramp_phase = 0;
            end
            if (!fired && envelope * 20 < int'(threshold) * 17) armed = 1'b0;

            gain    = 65536;
            running = 1'b0;
            if (ramp_on) begin
                idx = ramp_phase >> PHASE_FRAC_BITS;
                if (ramp_count < length_max && idx < GAIN_TABLE_DEPTH) begin
                    gain       = gain_curve[idx];
                    running    = 1'b1;
                    ramp_phase = ramp_phase + phase_step;
                    ramp_count = (ramp_count + 1) & ((1 << RAMP_COUNT_BITS) - 1);
                    if (ramp_count >= length_max ||
                        (ramp_phase >> PHASE_FRAC_BITS) >= GAIN_TABLE_DEPTH)
                        ramp_on = 1'b0;
                end else begin
                    ramp_on = 1'b0;
                end
            end

            prod = longint'(x) * longint'(gain);
            y    = prod >>> 16;
            r.sample  = y[SAMPLE_BITS-1:0];
            r.level   = envelope[SAMPLE_BITS-1:0];
            r.running = running;
            pending_results.push_back(r);
            samples_noted++;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s at result %0d: got %0d, want %0d",
                     what, checked, got, want);
            mismatches++;
        endtask

        task check_result(logic signed [SAMPLE_BITS-1:0] s, logic [SAMPLE_BITS-1:0] lvl,
                          logic run);
            t_swell_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", s, 0);
                return;
            end
            want = pending_results.pop_front();
            if (s !== want.sample) report_mismatch("out_sample", s, want.sample);
            if (lvl !== want.level) report_mismatch("envelope_level", lvl, want.level);
            if (run !== want.running) report_mismatch("swell_running", run, want.running);
            if (want.running) ramp_results++;
            checked++;
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_in_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_out_sample;
    logic        [SAMPLE_BITS-1:0] o_envelope_level;
    logic                          o_swell_running;
    logic                          i_cfg_we = 1'b0;
    logic        [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic        [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    t_swell_scoreboard sb;
    int  stall_left = 0;
    int  out_hold_request = 0;
    bit  in_steady = 1'b0;
    bit  out_steady = 1'b0;
    int  idle_cycles = 0;
    int  input_stall_cycles = 0;
    int  settings_applied = 1;

    logic signed [SAMPLE_BITS-1:0] opening_samples [12] = '{
        16'sh0000, 16'sh0001, 16'shFFFF, 16'sd100, -16'sd100, 16'sh7FFF,
        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh5555, 16'shAAAA
    };

    envelope_triggered_volume_swell dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_sample      (i_in_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_sample     (o_out_sample),
        .o_envelope_level (o_envelope_level),
        .o_swell_running  (o_swell_running),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        if (out_hold_request > 0) begin
            stall_left       = out_hold_request;
            out_hold_request = 0;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (out_steady || $urandom_range(0, 99) < 65) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b1;
            stall_left  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(8, 25);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_sample, o_envelope_level, o_swell_running);
        if (i_in_valid && o_in_stall) input_stall_cycles++;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (in_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_in_sample <= x;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(x);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        sb.write_reg(idx, v[CFG_DATA_BITS-1:0]);
    endtask

    task automatic apply_settings(input int unsigned atk, input int unsigned dec,
                                  input int unsigned thr, input int unsigned step,
                                  input int unsigned len);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_LENGTH_MAX, len);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // alternating quiet and loud runs so the swell arms, ramps and releases
    task automatic run_random(input int count);
        int sent;
        int run_len;
        int q;
        bit loud;
        logic signed [SAMPLE_BITS-1:0] x;
        sent = 0;
        loud = 1'b0;
        q    = sb.threshold / 3;
        while (sent < count) begin
            loud    = !loud;
            run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
                                                 : $urandom_range(20, 50);
            for (int k = 0; k < run_len && sent < count; k++) begin
                if ($urandom_range(0, 9) == 0)
                    x = SAMPLE_BITS'($urandom);
                else if (!loud)
                    x = SAMPLE_BITS'($urandom_range(0, 2 * q) - q);
                else if ($urandom_range(0, 1) == 1)
                    x = SAMPLE_BITS'($urandom);
                else if ($urandom_range(0, 1) == 1)
                    x = SAMPLE_BITS'($urandom_range(16384, 32767));
                else
                    x = SAMPLE_BITS'(-$urandom_range(16384, 32768));
                send_sample(x);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes, slow envelope
        foreach (opening_samples[i]) send_sample(opening_samples[i]);
        run_random(60);
        drain_results();

        // instant envelope, ramp runs off the end of the curve; long result hold-off
        apply_settings(0, 0, 1000, 64 << PHASE_FRAC_BITS, 20'hFFFFF);
        @(posedge i_clk);
        out_hold_request = 60;
        in_steady        = 1'b1;
        run_random(24);
        in_steady = 1'b0;
        run_random(56);
        drain_results();

        // one-sample ramp, largest phase step, no idling either side
        apply_settings(30000, 40000, 4000, 24'hFFFFFF, 1);
        in_steady  = 1'b1;
        out_steady = 1'b1;
        run_random(60);
        in_steady  = 1'b0;
        out_steady = 1'b0;
        drain_results();

        // zero threshold fires once; zero phase step holds the first curve entry
        apply_settings(16'hFFFF, 30000, 0, 0, 5);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        run_random(40);
        drain_results();

        // full-scale threshold, zero ramp length
        apply_settings(0, 16'hFFFF, 32768, 1000, 0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        run_random(40);
        drain_results();

        repeat (3) begin
            apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 32768) >> $urandom_range(0, 4),
                           $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12),
                           $urandom_range(1, 20'hFFFFF) >> $urandom_range(0, 16));
            run_random(40);
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch("results never returned", 0, sb.pending_results.size());

        $display("covered %0d samples over %0d register settings, %0d results checked",
                 sb.samples_noted, settings_applied, sb.checked);
        $display("%0d results under the gain ramp, %0d cycles of input back-pressure",
                 sb.ramp_results, input_stall_cycles);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
